// ===== hw/rtl/npa_pkg.sv =====
package npa_pkg;

    localparam int NODES = 64;
    localparam int ID_W  = 6;
    localparam int CNT_W = 7;

    typedef logic [ID_W-1:0]  t_id;
    typedef logic [CNT_W-1:0] t_cnt;

    localparam logic ACT_GET    = 1'b0;
    localparam logic ACT_RETURN = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_NOT_USED = 2'd2;

    typedef struct packed {
        logic action;
        t_id  node_id;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        t_id        granted_node;
        t_cnt       free_count;
        t_cnt       used_count;
    } t_out_item;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic load;
        logic rd;
        logic wr_unlink;
        logic wr_self;
        logic wr_insert;
        logic commit;
    } t_cmd;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic reject;
        logic out_free;
    } t_sts;

    // Link values that an entry holds before it is first written.
    function automatic t_id f_next_init(t_id idx);
        if (int'(idx) == NODES - 1) begin
            return '0;
        end
        return idx + t_id'(1);
    endfunction

    function automatic t_id f_prev_init(t_id idx);
        if (idx == '0) begin
            return t_id'(NODES - 1);
        end
        return idx - t_id'(1);
    endfunction

endpackage

// ===== hw/rtl/node_pool_allocator.sv =====
// Node pool allocator for a fixed pool of node IDs, kept as a free ring and
// an in-use ring in shared next/prev link memories.
// Input channel (i_in_valid / o_in_stall / i_in_data): one request per
// transaction, either a get or the return of a node ID.
// Output channel (o_out_valid / i_out_stall / o_out_data): one response per
// request with status, granted node and the free and used counts afterwards.
// A request is worked on one at a time. A successful request reads the
// link memories and then writes them in the unlink, self and insert
// states, since each link memory takes one write per cycle.
// A rejected request (empty pool, or a return of a node not in use) is
// answered from the read state. The next request is accepted in the cycle
// after the response is loaded.
// The response sits in an output register; if the receiver stalls, the
// block holds the finished request until that register frees up, and
// o_in_stall stays high meanwhile.
// Reset puts all nodes on the free ring in ascending order, with no clearing
// pass: the block can take a request in the first cycle after reset.
module node_pool_allocator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  npa_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output npa_pkg::t_out_item o_out_data
);
    import npa_pkg::*;

    t_cmd cmd;
    t_sts sts;

    npa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    npa_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Every node is on exactly one of the two rings.
    a_count_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
        ((8'(o_out_data.free_count) + 8'(o_out_data.used_count)) == 8'(NODES)))
        else $error("free and used counts do not add up to the pool size");

    // Only a successful get hands out a node.
    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status != ST_OK)) |->
        (o_out_data.granted_node == '0))
        else $error("node granted on a rejected request");

    // An accepted request keeps the input side busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after a transaction was accepted");

    // A commit always lands in a free output register.
    a_commit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> sts.out_free)
        else $error("response committed over a pending one");

endmodule

// ===== hw/rtl/npa_ctrl.sv =====
module npa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  npa_pkg::t_sts  i_sts,
    output npa_pkg::t_cmd  o_cmd
);
    import npa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_UNLINK,
        S_SELF,
        S_INSERT,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   n_cmd;

    always_comb begin
        n_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                n_cmd.rd = 1'b1;
                if (i_sts.reject) begin
                    // A rejected request changes no state, so it can finish here.
                    if (i_sts.out_free) begin
                        n_cmd.commit = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        n_state = S_FINISH;
                    end
                end else begin
                    n_state = S_UNLINK;
                end
            end
            S_UNLINK: begin
                n_cmd.wr_unlink = 1'b1;
                n_state         = S_SELF;
            end
            S_SELF: begin
                n_cmd.wr_self = 1'b1;
                n_state       = S_INSERT;
            end
            S_INSERT: begin
                n_cmd.wr_insert = 1'b1;
                if (i_sts.out_free) begin
                    n_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    n_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd      = n_cmd;
    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ===== hw/rtl/npa_dp.sv =====
module npa_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  npa_pkg::t_cmd      i_cmd,
    output npa_pkg::t_sts      o_sts,
    input  npa_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output npa_pkg::t_out_item o_out_data
);
    import npa_pkg::*;

    // Link memories; an entry whose valid bit is clear reads as its reset value.
    t_id              r_next_mem [NODES];
    t_id              r_prev_mem [NODES];
    logic [NODES-1:0] r_next_vld;
    logic [NODES-1:0] r_prev_vld;
    logic [NODES-1:0] r_in_use;

    logic      r_action;
    t_id       r_id;
    t_id       r_free_head;
    t_id       r_use_head;
    t_cnt      r_free_total;
    t_cnt      r_use_total;
    t_id       r_q_raw;
    t_id       r_p_raw;
    t_id       r_t_raw;
    logic      r_q_vld;
    logic      r_p_vld;
    logic      r_t_vld;
    logic      r_out_valid;
    t_out_item r_out;

    t_id       n_free_head;
    t_id       n_use_head;
    t_cnt      n_free_total;
    t_cnt      n_use_total;
    t_out_item n_out;

    logic is_get;
    t_id  node_x;
    t_id  head_b;
    t_cnt cnt_a;
    t_cnt cnt_b;
    logic a_multi;
    logic b_nonempty;
    t_id  link_q;
    t_id  link_p;
    t_id  link_t;
    logic reject;
    logic commit_ok;

    logic nx_we;
    t_id  nx_addr;
    t_id  nx_data;
    logic pv_we;
    t_id  pv_addr;
    t_id  pv_data;

    // The node moves from ring A to ring B: free to use on a get, use to free on a return.
    assign is_get     = (r_action == ACT_GET);
    assign node_x     = is_get ? r_free_head : r_id;
    assign head_b     = is_get ? r_use_head : r_free_head;
    assign cnt_a      = is_get ? r_free_total : r_use_total;
    assign cnt_b      = is_get ? r_use_total : r_free_total;
    assign a_multi    = (cnt_a > t_cnt'(1));
    assign b_nonempty = (cnt_b != '0);

    assign link_q = r_q_vld ? r_q_raw : f_next_init(node_x);
    assign link_p = r_p_vld ? r_p_raw : f_prev_init(node_x);
    assign link_t = r_t_vld ? r_t_raw : f_prev_init(head_b);

    assign reject = is_get ? (r_free_total == '0)
                           : ((t_cnt'(r_id) >= t_cnt'(NODES)) || !r_in_use[r_id]);
    assign commit_ok = i_cmd.commit && !reject;

    always_comb begin
        nx_we   = 1'b0;
        nx_addr = node_x;
        nx_data = node_x;
        pv_we   = 1'b0;
        pv_addr = node_x;
        pv_data = node_x;
        if (i_cmd.wr_unlink && a_multi) begin
            nx_we   = 1'b1;
            nx_addr = link_p;
            nx_data = link_q;
            pv_we   = 1'b1;
            pv_addr = link_q;
            pv_data = link_p;
        end else if (i_cmd.wr_self) begin
            nx_we   = 1'b1;
            nx_addr = node_x;
            nx_data = b_nonempty ? head_b : node_x;
            pv_we   = 1'b1;
            pv_addr = node_x;
            pv_data = b_nonempty ? link_t : node_x;
        end else if (i_cmd.wr_insert && b_nonempty) begin
            nx_we   = 1'b1;
            nx_addr = link_t;
            nx_data = node_x;
            pv_we   = 1'b1;
            pv_addr = head_b;
            pv_data = node_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (nx_we) begin
            r_next_mem[nx_addr] <= nx_data;
        end
        if (pv_we) begin
            r_prev_mem[pv_addr] <= pv_data;
        end
        if (i_cmd.rd) begin
            r_q_raw <= r_next_mem[node_x];
            r_p_raw <= r_prev_mem[node_x];
            r_t_raw <= r_prev_mem[head_b];
            r_q_vld <= r_next_vld[node_x];
            r_p_vld <= r_prev_vld[node_x];
            r_t_vld <= r_prev_vld[head_b];
        end
        if (i_cmd.load) begin
            r_action <= i_in_data.action;
            r_id     <= i_in_data.node_id;
        end
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    always_comb begin
        n_free_head  = r_free_head;
        n_use_head   = r_use_head;
        n_free_total = r_free_total;
        n_use_total  = r_use_total;
        if (commit_ok) begin
            if (is_get) begin
                n_free_total = r_free_total - t_cnt'(1);
                n_free_head  = a_multi ? link_q : '0;
                n_use_head   = node_x;
                n_use_total  = r_use_total + t_cnt'(1);
            end else begin
                n_use_total = r_use_total - t_cnt'(1);
                if (!a_multi) begin
                    n_use_head = '0;
                end else if (r_use_head == node_x) begin
                    n_use_head = link_q;
                end
                n_free_head  = node_x;
                n_free_total = r_free_total + t_cnt'(1);
            end
        end
    end

    always_comb begin
        n_out.status       = reject ? (is_get ? ST_EMPTY : ST_NOT_USED) : ST_OK;
        n_out.granted_node = (!reject && is_get) ? node_x : '0;
        n_out.free_count   = n_free_total;
        n_out.used_count   = n_use_total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_vld   <= '0;
            r_prev_vld   <= '0;
            r_in_use     <= '0;
            r_free_head  <= '0;
            r_use_head   <= '0;
            r_free_total <= t_cnt'(NODES);
            r_use_total  <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (nx_we) begin
                r_next_vld[nx_addr] <= 1'b1;
            end
            if (pv_we) begin
                r_prev_vld[pv_addr] <= 1'b1;
            end
            if (commit_ok) begin
                r_in_use[node_x] <= is_get;
            end
            r_free_head  <= n_free_head;
            r_use_head   <= n_use_head;
            r_free_total <= n_free_total;
            r_use_total  <= n_use_total;
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.reject   = reject;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out;

endmodule

// ===== dv/tb_node_pool_allocator.sv =====
module tb_node_pool_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    import npa_pkg::*;

    localparam int RANDOM_ITEMS = 1150;
    localparam int IDLE_LIMIT   = 3000;
    localparam int TAIL_CYCLES  = 20;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 250;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_data   = '0;
    logic      out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;

    node_pool_allocator dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data)
    );

    initial forever #5 clk = ~clk;

    // Pool state as the block should hold it.
    t_id  link_next [NODES];
    t_id  link_prev [NODES];
    logic node_busy [NODES];
    t_id  free_head_q;
    t_id  use_head_q;
    int   free_nodes;
    int   used_nodes;

    // Stimulus side tracking: the free ring behaves as a stack seeded 0..N-1.
    t_id gen_free [$];
    t_id gen_used [$];

    t_in_item  pending_requests [$];
    t_out_item expected_responses [$];

    int total_requests    = 0;
    int requests_accepted = 0;
    int responses_checked = 0;
    int failures          = 0;
    int idle_cycles       = 0;
    int hold_left         = 0;
    bit hold_done         = 1'b0;

    function automatic void reset_pool_model();
        for (int i = 0; i < NODES; i++) begin
            link_next[i] = t_id'((i + 1) % NODES);
            link_prev[i] = t_id'((i + NODES - 1) % NODES);
            node_busy[i] = 1'b0;
        end
        free_head_q = '0;
        use_head_q  = '0;
        free_nodes  = NODES;
        used_nodes  = 0;
    endfunction

    function automatic void detach(t_id n);
        link_next[link_prev[n]] = link_next[n];
        link_prev[link_next[n]] = link_prev[n];
    endfunction

    // Places n just ahead of head h, which closes the ring behind it.
    function automatic void attach(t_id n, t_id h);
        t_id tail;
        tail          = link_prev[h];
        link_prev[n]  = tail;
        link_next[n]  = h;
        link_next[tail] = n;
        link_prev[h]  = n;
    endfunction

    function automatic void make_lone(t_id n);
        link_next[n] = n;
        link_prev[n] = n;
    endfunction

    function automatic t_out_item serve_request(t_in_item req);
        t_out_item rsp;
        t_id       n;
        rsp              = '0;
        rsp.status       = ST_OK;
        rsp.granted_node = '0;
        if (req.action == ACT_GET) begin
            if (free_nodes == 0) begin
                rsp.status = ST_EMPTY;
            end else begin
                n = free_head_q;
                free_nodes--;
                if (free_nodes == 0) begin
                    free_head_q = '0;
                end else begin
                    detach(n);
                    free_head_q = link_next[n];
                end
                if (used_nodes == 0) begin
                    make_lone(n);
                end else begin
                    attach(n, use_head_q);
                end
                use_head_q = n;
                used_nodes++;
                node_busy[n] = 1'b1;
                rsp.granted_node = n;
            end
        end else begin
            n = req.node_id;
            if (int'(n) >= NODES || !node_busy[n]) begin
                rsp.status = ST_NOT_USED;
            end else begin
                used_nodes--;
                if (used_nodes == 0) begin
                    use_head_q = '0;
                end else begin
                    detach(n);
                    if (use_head_q == n) begin
                        use_head_q = link_next[n];
                    end
                end
                if (free_nodes == 0) begin
                    make_lone(n);
                end else begin
                    attach(n, free_head_q);
                end
                free_head_q = n;
                free_nodes++;
                node_busy[n] = 1'b0;
            end
        end
        rsp.free_count = t_cnt'(free_nodes);
        rsp.used_count = t_cnt'(used_nodes);
        return rsp;
    endfunction

    function automatic t_id any_id();
        return t_id'($urandom_range(0, NODES - 1));
    endfunction

    function automatic void queue_get(t_id junk);
        t_in_item item;
        item.action  = ACT_GET;
        item.node_id = junk;
        if (gen_free.size() != 0) begin
            gen_used.push_back(gen_free.pop_front());
        end
        pending_requests.push_back(item);
    endfunction

    function automatic void queue_return(t_id id);
        t_in_item item;
        item.action  = ACT_RETURN;
        item.node_id = id;
        for (int k = 0; k < gen_used.size(); k++) begin
            if (gen_used[k] == id) begin
                gen_used.delete(k);
                gen_free.push_front(id);
                break;
            end
        end
        pending_requests.push_back(item);
    endfunction

    // Sender idles 34% then 61% of cycles, the receiver the other way round, then neither.
    function automatic int idle_pct(int accepted, bit receiver);
        if (accepted < 400) begin
            return receiver ? 61 : 34;
        end
        if (accepted < 800) begin
            return receiver ? 34 : 61;
        end
        return 0;
    endfunction

    always @(posedge clk) begin : drive_requests
        logic     next_valid;
        t_in_item next_item;
        next_valid = in_valid;
        next_item  = in_data;
        if (!rst_n) begin
            next_valid = 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                expected_responses.push_back(serve_request(in_data));
                void'(pending_requests.pop_front());
                requests_accepted <= requests_accepted + 1;
                next_valid = 1'b0;
            end
            if (!next_valid && pending_requests.size() != 0 &&
                $urandom_range(0, 99) >= idle_pct(requests_accepted, 1'b0)) begin
                next_valid = 1'b1;
                next_item  = pending_requests[0];
            end
        end
        in_valid <= next_valid;
        in_data  <= next_item;
    end

    always @(posedge clk) begin : check_responses
        t_out_item want;
        logic      next_stall;
        if (rst_n && o_out_valid && !out_stall) begin
            if (expected_responses.size() == 0) begin
                $error("response with no request pending: %p", o_out_data);
                failures++;
            end else begin
                want = expected_responses.pop_front();
                if (o_out_data.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_out_data.status);
                    failures++;
                end
                if (o_out_data.granted_node !== want.granted_node) begin
                    $error("granted_node: expected %0d, actual %0d",
                           want.granted_node, o_out_data.granted_node);
                    failures++;
                end
                if (o_out_data.free_count !== want.free_count) begin
                    $error("free_count: expected %0d, actual %0d",
                           want.free_count, o_out_data.free_count);
                    failures++;
                end
                if (o_out_data.used_count !== want.used_count) begin
                    $error("used_count: expected %0d, actual %0d",
                           want.used_count, o_out_data.used_count);
                    failures++;
                end
            end
            responses_checked <= responses_checked + 1;
        end
        // One long hold-off lets the block back up and stall its input.
        if (hold_left > 0) begin
            next_stall = 1'b1;
            hold_left--;
        end else if (!hold_done && responses_checked == HOLD_AT) begin
            next_stall = 1'b1;
            hold_left  = HOLD_CYCLES;
            hold_done  = 1'b1;
        end else begin
            next_stall = ($urandom_range(0, 99) < idle_pct(requests_accepted, 1'b1));
        end
        out_stall <= next_stall;
    end

    always @(posedge clk) begin : watchdog
        if (!rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL node_pool_allocator");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : run_test
        int directed_count;
        int pick;
        int segment;
        reset_pool_model();
        for (int i = 0; i < NODES; i++) begin
            gen_free.push_back(t_id'(i));
        end

        // Directed: grants in order, LIFO reuse, bad returns, ring emptying,
        // removal from the middle, head and tail of the in-use ring.
        queue_get(t_id'(0));
        queue_get(t_id'(NODES - 1));
        queue_return(t_id'(NODES - 1));
        queue_return(t_id'(0));
        queue_get(t_id'(0));
        queue_return(t_id'(1));
        queue_return(t_id'(1));
        queue_return(t_id'(0));
        queue_return(t_id'(0));
        queue_get(t_id'(21));
        queue_get(t_id'(42));
        queue_get(t_id'(NODES - 1));
        queue_return(gen_used[1]);
        queue_return(gen_used[1]);
        queue_return(gen_used[0]);
        queue_get(t_id'(NODES - 1));
        queue_get(t_id'(0));
        queue_return(t_id'(NODES - 1));
        queue_return(gen_used[0]);
        queue_return(gen_used[0]);
        directed_count = pending_requests.size();

        while (pending_requests.size() < directed_count + RANDOM_ITEMS) begin
            segment = $urandom_range(0, 9);
            if (segment < 2) begin
                // Fill the pool and knock on it a few times once empty.
                repeat (gen_free.size() + $urandom_range(1, 4)) queue_get(any_id());
            end else if (segment < 4) begin
                // Drain in random order with the odd stray return.
                while (gen_used.size() != 0) begin
                    if ($urandom_range(0, 7) == 0) begin
                        queue_return(any_id());
                    end else begin
                        queue_return(gen_used[$urandom_range(0, gen_used.size() - 1)]);
                    end
                end
                queue_return(any_id());
            end else begin
                repeat (40) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 45 || (pick < 85 && gen_used.size() == 0)) begin
                        queue_get(any_id());
                    end else if (pick < 85) begin
                        queue_return(gen_used[$urandom_range(0, gen_used.size() - 1)]);
                    end else begin
                        queue_return(any_id());
                    end
                end
            end
        end
        total_requests = pending_requests.size();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (requests_accepted != total_requests || responses_checked != total_requests) begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (failures == 0 && expected_responses.size() == 0) begin
            $display("PASS node_pool_allocator");
        end else begin
            $display("FAIL node_pool_allocator");
        end
        $finish;
    end

endmodule
